FILE: hw/rtl/esu_pkg.sv
package esu_pkg;

	// Decoder phase between input items
	typedef enum logic [2:0] {
		PH_PLAIN = 3'd0,
		PH_ESC   = 3'd1,
		PH_ZERO0 = 3'd2,
		PH_ZERO1 = 3'd3,
		PH_HEX   = 3'd4
	} esu_phase_t;

	localparam int MAX_HEX_DIGITS_DEF = 16;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_X   = 8'h78;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_NUL    = 8'h00;

	function automatic logic is_dec(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	// {valid, nibble}; letters map via low nibble + 9
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/esu_decode.sv
module esu_decode #(
	parameter int MAX_HEX_DIGITS = esu_pkg::MAX_HEX_DIGITS_DEF,
	localparam int HEX_W     = 4 * MAX_HEX_DIGITS,
	localparam int HCNT_W    = $clog2(MAX_HEX_DIGITS + 1),
	localparam int HEX_BYTES = (MAX_HEX_DIGITS + 1) / 2,
	localparam int BUF_DEPTH = (HEX_BYTES + 1 > 3) ? HEX_BYTES + 1 : 3,
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1),
	localparam int NB_W      = $clog2(HEX_BYTES + 1)
) (
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	input  esu_pkg::esu_phase_t         phase,
	input  logic [3:0]                  held,
	input  logic [HEX_W-1:0]            hex_val,
	input  logic [HCNT_W-1:0]           hex_cnt,
	output esu_pkg::esu_phase_t         phase_nxt,
	output logic [3:0]                  held_nxt,
	output logic [HEX_W-1:0]            hex_val_nxt,
	output logic [HCNT_W-1:0]           hex_cnt_nxt,
	output logic [BUF_DEPTH-1:0][7:0]   res_bytes,
	output logic [CNT_W-1:0]            res_cnt
);
	import esu_pkg::*;

	logic [4:0]              nib;
	logic [HEX_W-1:0]        hv_sh;
	logic [HCNT_W-1:0]       hc_inc;
	logic                    flush;
	logic [HEX_W-1:0]        flush_val;
	logic [HCNT_W-1:0]       flush_cnt;
	logic                    plain_pend;
	logic [2:0][7:0]         tail;
	logic [1:0]              tcnt;
	logic [NB_W-1:0]         nb;
	logic [HCNT_W:0]         fc_plus;
	logic [HEX_BYTES*8-1:0]  fv_pad;

	assign nib    = hex_nibble(in_byte);
	assign hv_sh  = {hex_val[HEX_W-5:0], nib[3:0]};
	assign hc_inc = hex_cnt + 1'b1;

	always_comb begin
		phase_nxt   = phase;
		held_nxt    = held;
		hex_val_nxt = hex_val;
		hex_cnt_nxt = hex_cnt;
		flush       = 1'b0;
		flush_val   = hex_val;
		flush_cnt   = hex_cnt;
		plain_pend  = 1'b0;
		tail        = '0;
		tcnt        = 2'd0;

		case (phase)
			PH_ESC: begin
				phase_nxt = PH_PLAIN;
				if (in_byte == CH_LC_T) begin
					tail[0] = CH_TAB;
					tcnt    = 2'd1;
				end else if (in_byte == CH_LC_N) begin
					tail[0] = CH_NL;
					tcnt    = 2'd1;
				end else if (in_byte == CH_ZERO) begin
					phase_nxt = PH_ZERO0;
				end else if (in_byte == CH_LC_X) begin
					hex_val_nxt = '0;
					hex_cnt_nxt = '0;
					phase_nxt   = PH_HEX;
				end else begin
					tail[0] = in_byte;
					tcnt    = 2'd1;
				end
			end
			PH_ZERO0: begin
				if (is_dec(in_byte)) begin
					held_nxt  = in_byte[3:0];
					phase_nxt = PH_ZERO1;
				end else begin
					tail[0]    = CH_NUL;
					tcnt       = 2'd1;
					phase_nxt  = PH_PLAIN;
					plain_pend = 1'b1;
				end
			end
			PH_ZERO1: begin
				phase_nxt = PH_PLAIN;
				held_nxt  = 4'd0;
				if (is_dec(in_byte)) begin
					tail[0] = {1'b0, held, 3'b000} + {4'd0, in_byte[3:0]};
					tcnt    = 2'd1;
				end else begin
					tail[0]    = CH_NUL;
					tail[1]    = {CH_ZERO[7:4], held};
					tcnt       = 2'd2;
					plain_pend = 1'b1;
				end
			end
			PH_HEX: begin
				if (nib[4]) begin
					hex_val_nxt = hv_sh;
					hex_cnt_nxt = hc_inc;
					if (hc_inc >= HCNT_W'(MAX_HEX_DIGITS)) begin
						// run is full: emit right away
						flush       = 1'b1;
						flush_val   = hv_sh;
						flush_cnt   = hc_inc;
						hex_val_nxt = '0;
						hex_cnt_nxt = '0;
						phase_nxt   = PH_PLAIN;
					end
				end else begin
					flush       = 1'b1;
					hex_val_nxt = '0;
					hex_cnt_nxt = '0;
					phase_nxt   = PH_PLAIN;
					plain_pend  = 1'b1;
				end
			end
			default: begin
				phase_nxt  = PH_PLAIN;
				plain_pend = 1'b1;
			end
		endcase

		// the byte that broke an escape is treated as plain text
		if (plain_pend) begin
			if (in_byte == CH_BSLASH) begin
				phase_nxt = PH_ESC;
			end else begin
				tail[tcnt] = in_byte;
				tcnt       = tcnt + 2'd1;
			end
		end

		// end of string: flush whatever escape is still open
		if (in_last) begin
			case (phase_nxt)
				PH_ESC, PH_ZERO0: begin
					tail[tcnt] = CH_NUL;
					tcnt       = tcnt + 2'd1;
				end
				PH_ZERO1: begin
					tail[tcnt] = CH_NUL;
					tcnt       = tcnt + 2'd1;
					tail[tcnt] = {CH_ZERO[7:4], held_nxt};
					tcnt       = tcnt + 2'd1;
				end
				PH_HEX: begin
					flush     = 1'b1;
					flush_val = hex_val_nxt;
					flush_cnt = hex_cnt_nxt;
				end
				default: begin
				end
			endcase
			phase_nxt   = PH_PLAIN;
			held_nxt    = 4'd0;
			hex_val_nxt = '0;
			hex_cnt_nxt = '0;
		end
	end

	// hex run emits max(1, ceil(n/2)) bytes
	assign fc_plus = {1'b0, flush_cnt} + 1'b1;
	assign nb = !flush ? '0 :
		(flush_cnt == '0) ? NB_W'(1) : NB_W'(fc_plus >> 1);
	assign fv_pad = (HEX_BYTES*8)'(flush_val);

	// hex bytes big-endian first, then the tail bytes
	always_comb begin
		for (int k = 0; k < BUF_DEPTH; k++) begin
			res_bytes[k] = '0;
			if (k < nb) begin
				for (int j = 0; j < HEX_BYTES; j++) begin
					if (j + k + 1 == nb) begin
						res_bytes[k] = fv_pad[8*j +: 8];
					end
				end
			end else begin
				for (int t = 0; t < 3; t++) begin
					if (k == nb + t) begin
						res_bytes[k] = tail[t];
					end
				end
			end
		end
	end

	assign res_cnt = CNT_W'(nb) + CNT_W'(tcnt);

endmodule

FILE: hw/rtl/esu_burst.sv
module esu_burst #(
	parameter int DEPTH = 9,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [DEPTH-1:0][7:0]   ld_bytes,
	input  logic [CNT_W-1:0]        ld_cnt,
	input  logic                    ld_last,
	output logic                    can_load,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              out_byte,
	output logic                    run_last,
	output logic                    string_done
);
	logic [DEPTH-1:0][7:0] buf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  last_q;
	logic                  take;

	assign out_valid = (cnt_q != '0);
	assign take      = out_valid && out_ready;
	assign can_load  = (cnt_q == '0) || (take && cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= ld_cnt;
			last_q <= ld_last;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output shifts toward entry 0
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= ld_bytes;
		end else if (take) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

	assign out_byte    = buf_q[0];
	assign run_last    = (cnt_q == CNT_W'(1));
	assign string_done = run_last && last_q;

endmodule

FILE: hw/rtl/escape_sequence_unescaper_core.sv
// Path: an accepted item passes through the input register, then the result
// buffer, before its results show on the output; a busy buffer can hold it.
// Throughput: one input item per cycle while each yields at most one item and the
// output is ready; an item yielding several results holds the input while the
// result buffer drains one item per cycle when the output is ready (hex runs give up to ceil(MAX_HEX_DIGITS/2)+1).
// Reset: arst_n asynchronous, active low; clears the input and result valids
// and returns the decoder to plain text with no pending escape.
module escape_sequence_unescaper_core #(
	parameter int MAX_HEX_DIGITS = esu_pkg::MAX_HEX_DIGITS_DEF,
	localparam int HEX_W     = 4 * MAX_HEX_DIGITS,
	localparam int HCNT_W    = $clog2(MAX_HEX_DIGITS + 1),
	localparam int HEX_BYTES = (MAX_HEX_DIGITS + 1) / 2,
	localparam int BUF_DEPTH = (HEX_BYTES + 1 > 3) ? HEX_BYTES + 1 : 3,
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
	input  logic       s_axis_tlast,    // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // [7:0] out_byte
	output logic       m_axis_tuser,    // run_last
	output logic       m_axis_tlast     // string_done
);
	import esu_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decoder state carried between items
	esu_phase_t         phase_q;
	logic [3:0]         held_q;
	logic [HEX_W-1:0]   hex_value_q;
	logic [HCNT_W-1:0]  hex_count_q;

	esu_phase_t                 phase_nxt;
	logic [3:0]                 held_nxt;
	logic [HEX_W-1:0]           hex_val_nxt;
	logic [HCNT_W-1:0]          hex_cnt_nxt;
	logic [BUF_DEPTH-1:0][7:0]  res_bytes;
	logic [CNT_W-1:0]           res_cnt;

	logic can_load;
	logic load;
	logic in_take;

	// The input register moves into the result buffer once the buffer is
	// empty or is handing over its final item this cycle. The decoder state
	// advances at that same edge, so each item sees the state its
	// predecessor left behind.
	assign load          = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_PLAIN;
			held_q      <= '0;
			hex_value_q <= '0;
			hex_count_q <= '0;
		end else if (load) begin
			phase_q     <= phase_nxt;
			held_q      <= held_nxt;
			hex_value_q <= hex_val_nxt;
			hex_count_q <= hex_cnt_nxt;
		end
	end

	// Single-pass decode: next state plus the full list of decoded bytes
	esu_decode #(
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS)
	) u_decode (
		.in_byte     (byte_s1),
		.in_last     (last_s1),
		.phase       (phase_q),
		.held        (held_q),
		.hex_val     (hex_value_q),
		.hex_cnt     (hex_count_q),
		.phase_nxt   (phase_nxt),
		.held_nxt    (held_nxt),
		.hex_val_nxt (hex_val_nxt),
		.hex_cnt_nxt (hex_cnt_nxt),
		.res_bytes   (res_bytes),
		.res_cnt     (res_cnt)
	);

	// Result buffer: holds one item's decoded bytes and drains them in order
	esu_burst #(
		.DEPTH(BUF_DEPTH)
	) u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.ld_bytes    (res_bytes),
		.ld_cnt      (res_cnt),
		.ld_last     (last_s1),
		.can_load    (can_load),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.run_last    (m_axis_tuser),
		.string_done (m_axis_tlast)
	);

	// the final byte of a string always produces at least one item
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_s1) |-> (res_cnt != '0))
		else $error("end of string produced no item");

	// end of string leaves no pending escape
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_s1) |=> (phase_q == PH_PLAIN && hex_count_q == '0))
		else $error("escape state survived end of string");

	// hex digit count only lives inside a hex run
	a_hex_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEX) |-> (hex_count_q == '0))
		else $error("hex count nonzero outside hex run");

endmodule
